// ===== hdl/dtdz_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt delta block.
`default_nettype none
package dtdz_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 25;   // result bits of the 50-bit square root
  localparam int SqW         = 50;   // radicand width: (y*y+z*z) << 16
  localparam int VW          = 36;   // CORDIC vector width
  localparam int AW          = 32;   // angle accumulator width
  localparam int PitchMax    = 9000;

  localparam logic [0:0] RegSafe    = 1'b0;
  localparam logic [0:0] RegCaution = 1'b1;

  localparam logic [1:0] ZoneSafe    = 2'd0;
  localparam logic [1:0] ZoneCaution = 2'd1;
  localparam logic [1:0] ZoneOver    = 2'd2;

  // Square root in flight: remainder, partial root, the radicand and the x input.
  typedef struct packed {
    logic [SqW-1:0] rem;
    logic [25:0]    root;
    logic [SqW-1:0] n;
    logic signed [15:0] x;
  } sqrt_st_t;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [AW-1:0] ang;
  } cordic_st_t;

  function automatic logic signed [AW-1:0] atan_tab(input int i);
    logic signed [AW-1:0] t;
    case (i)
      0: t = 32'sd294912000;  1: t = 32'sd174096719;  2: t = 32'sd91987925;
      3: t = 32'sd46694507;   4: t = 32'sd23437865;   5: t = 32'sd11730358;
      6: t = 32'sd5866610;    7: t = 32'sd2933484;    8: t = 32'sd1466765;
      9: t = 32'sd733385;     10: t = 32'sd366693;    11: t = 32'sd183346;
      12: t = 32'sd91673;     13: t = 32'sd45837;     14: t = 32'sd22918;
      15: t = 32'sd11459;     16: t = 32'sd5730;      17: t = 32'sd2865;
      18: t = 32'sd1432;      19: t = 32'sd716;       20: t = 32'sd358;
      21: t = 32'sd179;       22: t = 32'sd90;        default: t = 32'sd45;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/dtdz_pitch.sv =====
// Pipelined pitch of one sensor: squares, bitwise square root, CORDIC, rounding.
`default_nettype none
module dtdz_pitch (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [15:0] z,
  output logic signed [14:0]      pitch
);

  localparam int S = dtdz_pkg::SqrtSteps;
  localparam int C = dtdz_pkg::CordicSteps;

  // Stage 0: squares.
  logic [31:0] ysq, zsq;
  logic signed [15:0] x0;
  always_ff @(posedge clk) begin
    if (en) begin
      ysq <= 32'(y * y);
      zsq <= 32'(z * z);
      x0  <= x;
    end
  end

  // Square root, one result bit per stage, most significant bit first.
  dtdz_pkg::sqrt_st_t sq [0:S];
  always_comb begin
    sq[0].rem  = '0;
    sq[0].root = '0;
    sq[0].n    = {1'b0, ({1'b0, ysq} + {1'b0, zsq}), 16'd0};
    sq[0].x    = x0;
  end

  for (genvar k = 0; k < S; k++) begin : g_sqrt
    localparam int B = S - 1 - k;
    logic [dtdz_pkg::SqW+1:0] trial;
    logic [dtdz_pkg::SqW+1:0] rem2;
    always_comb begin
      rem2  = {sq[k].rem, sq[k].n[2*B+1 -: 2]};
      trial = {24'd0, sq[k].root, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq[k+1].n <= sq[k].n;
        sq[k+1].x <= sq[k].x;
        if (rem2 >= trial) begin
          sq[k+1].rem  <= dtdz_pkg::SqW'(rem2 - trial);
          sq[k+1].root <= {sq[k].root[24:0], 1'b1};
        end else begin
          sq[k+1].rem  <= dtdz_pkg::SqW'(rem2);
          sq[k+1].root <= {sq[k].root[24:0], 1'b0};
        end
      end
    end
  end

  // CORDIC vectoring, one micro-rotation per stage.
  dtdz_pkg::cordic_st_t cs [0:C];
  always_comb begin
    cs[0].vx  = (sq[S].root < 26'd256) ? dtdz_pkg::VW'(256)
                                       : dtdz_pkg::VW'(sq[S].root);
    cs[0].vy  = dtdz_pkg::VW'(sq[S].x) <<< 8;
    cs[0].ang = '0;
  end

  for (genvar i = 0; i < C; i++) begin : g_cordic
    logic signed [dtdz_pkg::VW-1:0] dx, dy;
    always_comb begin
      dx = cs[i].vy >>> i;
      dy = cs[i].vx >>> i;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cs[i].vy[dtdz_pkg::VW-1]) begin
          cs[i+1].vx  <= cs[i].vx + dx;
          cs[i+1].vy  <= cs[i].vy - dy;
          cs[i+1].ang <= cs[i].ang + dtdz_pkg::atan_tab(i);
        end else begin
          cs[i+1].vx  <= cs[i].vx - dx;
          cs[i+1].vy  <= cs[i].vy + dy;
          cs[i+1].ang <= cs[i].ang - dtdz_pkg::atan_tab(i);
        end
      end
    end
  end

  // Round to the nearest centidegree, ties upward, then saturate.
  logic signed [dtdz_pkg::AW:0] rnd;
  logic signed [16:0] p;
  always_comb begin
    rnd = (dtdz_pkg::AW+1)'(cs[C].ang) + 33'sd32768;
    p   = 17'(rnd >>> 16);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (p > 17'sd9000)       pitch <= 15'sd9000;
      else if (p < -17'sd9000) pitch <= -15'sd9000;
      else                     pitch <= 15'(p);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dtdz_zone.sv =====
// Difference of the two pitches and zone classification, two register stages.
`default_nettype none
module dtdz_zone (
  input  wire logic               clk,
  input  wire logic signed [14:0] pitch_a_in,
  input  wire logic signed [14:0] pitch_b_in,
  input  wire logic [14:0]        safe_limit,
  input  wire logic [14:0]        caution_limit,
  output logic signed [14:0]      pitch_a,
  output logic signed [14:0]      pitch_b,
  output logic signed [15:0]      pitch_difference,
  output logic [1:0]              zone
);

  logic signed [14:0] pa1, pb1;
  logic signed [15:0] d1;
  logic [15:0] mag;

  always_ff @(posedge clk) begin
    pa1 <= pitch_a_in;
    pb1 <= pitch_b_in;
    d1  <= 16'(pitch_b_in) - 16'(pitch_a_in);
  end

  assign mag = d1[15] ? 16'(-d1) : 16'(d1);

  always_ff @(posedge clk) begin
    pitch_a          <= pa1;
    pitch_b          <= pb1;
    pitch_difference <= d1;
    if (mag < {1'b0, safe_limit})         zone <= dtdz_pkg::ZoneSafe;
    else if (mag < {1'b0, caution_limit}) zone <= dtdz_pkg::ZoneCaution;
    else                                  zone <= dtdz_pkg::ZoneOver;
  end

endmodule
`default_nettype wire

// ===== hdl/dual_tilt_delta_zone.sv =====
// Pipeline from start to done: 1 square, 25 root, 16 CORDIC, 1 round and 2 compare stages;
// the fixed-length pipeline takes one item every cycle.
// busy is never asserted: every stage advances each clock, and done is a one-cycle strobe.
// Synchronous reset clears the valid chain and loads the limits with 1500 and 4000.
`default_nettype none
module dual_tilt_delta_zone (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] accel_a_x,
  input  wire logic signed [15:0] accel_a_y,
  input  wire logic signed [15:0] accel_a_z,
  input  wire logic signed [15:0] accel_b_x,
  input  wire logic signed [15:0] accel_b_y,
  input  wire logic signed [15:0] accel_b_z,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [14:0]        cfg_data,
  output logic                    done,
  output logic signed [14:0]      pitch_a,
  output logic signed [14:0]      pitch_b,
  output logic signed [15:0]      pitch_difference,
  output logic [1:0]              zone
);

  localparam int Lat = dtdz_pkg::SqrtSteps + dtdz_pkg::CordicSteps + 4;

  logic [14:0] safe_limit, caution_limit;
  logic [Lat-1:0] vld;
  logic signed [14:0] pa, pb;

  assign busy = 1'b0;
  assign done = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      safe_limit    <= 15'd1500;
      caution_limit <= 15'd4000;
      vld           <= '0;
    end else begin
      vld <= {vld[Lat-2:0], start};
      if (cfg_we) begin
        unique case (cfg_index)
          dtdz_pkg::RegSafe:    safe_limit    <= cfg_data;
          dtdz_pkg::RegCaution: caution_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  dtdz_pitch u_pitch_a (.clk(clk), .en(1'b1), .x(accel_a_x), .y(accel_a_y),
                        .z(accel_a_z), .pitch(pa));
  dtdz_pitch u_pitch_b (.clk(clk), .en(1'b1), .x(accel_b_x), .y(accel_b_y),
                        .z(accel_b_z), .pitch(pb));

  dtdz_zone u_zone (
    .clk(clk), .pitch_a_in(pa), .pitch_b_in(pb),
    .safe_limit(safe_limit), .caution_limit(caution_limit),
    .pitch_a(pitch_a), .pitch_b(pitch_b),
    .pitch_difference(pitch_difference), .zone(zone)
  );

`ifndef NO_ASSERTIONS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[Lat-2])) else $error("done without an item in flight");
  a_zone_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (zone == dtdz_pkg::ZoneSafe || zone == dtdz_pkg::ZoneCaution ||
              zone == dtdz_pkg::ZoneOver)) else $error("illegal zone");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_a <= 15'sd9000 && pitch_a >= -15'sd9000 &&
              pitch_b <= 15'sd9000 && pitch_b >= -15'sd9000))
    else $error("pitch out of range");
`endif

endmodule
`default_nettype wire
